// ----- rtl/kdc_pkg.sv -----
// kdc_pkg: types and constants shared by the key debounce with cooldown block
// no dependencies; compiled before the interfaces and all modules
package kdc_pkg;

    // field widths
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned POLLS_W     = 4;
    localparam int unsigned MS_W        = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register reset values
    localparam logic                  RST_MODE          = 1'b1;
    localparam logic [POLLS_W-1:0]    RST_STABLE_POLLS  = 4'd3;
    localparam logic [MS_W-1:0]       RST_GUARD_MS      = 16'd30;
    localparam logic [MS_W-1:0]       RST_COOLDOWN_MS   = 16'd600;
    localparam logic                  RST_INITIAL_LEVEL = 1'b1;

    // key levels (active low)
    localparam logic LEVEL_PRESSED  = 1'b0;

    // debounce modes
    localparam logic MODE_COUNTING = 1'b0;
    localparam logic MODE_GUARD    = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_STABLE_POLLS  = 3'd1,
        CFG_GUARD_MS      = 3'd2,
        CFG_COOLDOWN_MS   = 3'd3,
        CFG_INITIAL_LEVEL = 3'd4
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic               mode;
        logic [POLLS_W-1:0] stable_polls;
        logic [MS_W-1:0]    guard_ms;
        logic [MS_W-1:0]    cooldown_ms;
        logic               initial_level;
    } t_cfg;

    // request to restart from a fresh key level
    typedef struct packed {
        logic load;
        logic level;
    } t_level_load;

    // debouncer state
    typedef struct packed {
        logic               stable_now;
        logic               last_raw;
        logic [POLLS_W-1:0] same_polls;
        logic [TIME_W-1:0]  last_event_time;
        logic               last_event_ok;
        logic [TIME_W-1:0]  press_start_time;
        logic               press_start_ok;
        logic [COUNT_W-1:0] events_seen;
        logic [TIME_W-1:0]  last_action_time;
        logic               last_action_ok;
        logic [COUNT_W-1:0] actions_fired;
        logic [COUNT_W-1:0] actions_rejected;
    } t_state;

    // one result item
    typedef struct packed {
        logic               stable_level;
        logic               event_valid;
        logic               event_is_press;
        logic [COUNT_W-1:0] event_total;
        logic [TIME_W-1:0]  press_duration_ms;
        logic               action_fire;
        logic               action_reject;
        logic [COUNT_W-1:0] action_total;
        logic [COUNT_W-1:0] reject_total;
    } t_result;

endpackage

// ----- rtl/kdc_if.sv -----
// kdc_if: valid/ready channel interfaces for polls, results and register writes
// depends on kdc_pkg for field widths

// poll channel
interface kdc_in_if;
    import kdc_pkg::*;
    logic              valid;
    logic              ready;
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output raw_level, output now_ms, input ready);
    modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

// result channel
interface kdc_out_if;
    import kdc_pkg::*;
    logic               valid;
    logic               ready;
    logic               stable_level;
    logic               event_valid;
    logic               event_is_press;
    logic [COUNT_W-1:0] event_total;
    logic [TIME_W-1:0]  press_duration_ms;
    logic               action_fire;
    logic               action_reject;
    logic [COUNT_W-1:0] action_total;
    logic [COUNT_W-1:0] reject_total;

    modport source (
        output valid, input ready,
        output stable_level, output event_valid, output event_is_press,
        output event_total, output press_duration_ms, output action_fire,
        output action_reject, output action_total, output reject_total
    );
    modport sink (
        input valid, output ready,
        input stable_level, input event_valid, input event_is_press,
        input event_total, input press_duration_ms, input action_fire,
        input action_reject, input action_total, input reject_total
    );
endinterface

// register write channel
interface kdc_cfg_if;
    import kdc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/key_debounce_with_cooldown.sv -----
// key_debounce_with_cooldown: one poll per cycle while the output is not stalled; a poll
// transfer fills the input register, and its result is then written to the output register.
// throughput one poll per cycle, set by the single evaluation pass between the
// input register and the output register; a stalled output stops the input.
// synchronous active-low reset restores register defaults and a released key level.
// depends on kdc_pkg, kdc_if, kdc_cfg and kdc_engine
module key_debounce_with_cooldown
    import kdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kdc_in_if.sink    i_in,
    kdc_cfg_if.sink   i_cfg,
    kdc_out_if.source o_out
);

    t_cfg              w_cfg;
    t_level_load       w_level_load;
    t_result           w_result;
    logic              w_out_free;
    logic              w_advance;
    logic              w_in_take;
    logic              r_in_valid;
    logic              n_in_valid;
    logic              r_in_raw;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;

    kdc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_cfg        (w_cfg),
        .o_level_load (w_level_load)
    );

    kdc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_level_load (w_level_load),
        .i_advance    (w_advance),
        .i_raw_level  (r_in_raw),
        .i_now_ms     (r_in_now),
        .o_result     (w_result)
    );

    // flow control between the two registers; no poll is taken while in reset
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_in.ready  = i_rst_n && (!r_in_valid || w_out_free);
    assign w_in_take   = i_in.valid && i_in.ready;
    assign n_in_valid  = w_in_take || (r_in_valid && !w_advance);
    assign n_out_valid = w_advance || (r_out_valid && !o_out.ready);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_raw <= i_in.raw_level;
            r_in_now <= i_in.now_ms;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    // result channel
    assign o_out.valid             = r_out_valid;
    assign o_out.stable_level      = r_out.stable_level;
    assign o_out.event_valid       = r_out.event_valid;
    assign o_out.event_is_press    = r_out.event_is_press;
    assign o_out.event_total       = r_out.event_total;
    assign o_out.press_duration_ms = r_out.press_duration_ms;
    assign o_out.action_fire       = r_out.action_fire;
    assign o_out.action_reject     = r_out.action_reject;
    assign o_out.action_total      = r_out.action_total;
    assign o_out.reject_total      = r_out.reject_total;

endmodule

// ----- rtl/kdc_cfg.sv -----
// kdc_cfg: configuration register file, written over the register write channel
// depends on kdc_pkg and kdc_cfg_if
module kdc_cfg
    import kdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kdc_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg,
    output t_level_load o_level_load
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    // able to take a write whenever out of reset
    assign i_cfg.ready = i_rst_n;
    assign w_wr        = i_cfg.valid && i_cfg.ready;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (i_cfg.index)
                CFG_MODE:          n_cfg.mode          = i_cfg.data[0];
                CFG_STABLE_POLLS:  n_cfg.stable_polls  = i_cfg.data[POLLS_W-1:0];
                CFG_GUARD_MS:      n_cfg.guard_ms      = i_cfg.data[MS_W-1:0];
                CFG_COOLDOWN_MS:   n_cfg.cooldown_ms   = i_cfg.data[MS_W-1:0];
                CFG_INITIAL_LEVEL: n_cfg.initial_level = i_cfg.data[0];
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= RST_MODE;
            r_cfg.stable_polls  <= RST_STABLE_POLLS;
            r_cfg.guard_ms      <= RST_GUARD_MS;
            r_cfg.cooldown_ms   <= RST_COOLDOWN_MS;
            r_cfg.initial_level <= RST_INITIAL_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // writing the start level also restarts the debouncer from it
    assign o_level_load.load  = w_wr && (i_cfg.index == CFG_INITIAL_LEVEL);
    assign o_level_load.level = i_cfg.data[0];
    assign o_cfg              = r_cfg;

endmodule

// ----- rtl/kdc_engine.sv -----
// kdc_engine: debouncer state and the single-pass evaluation of one poll
// depends on kdc_pkg
module kdc_engine
    import kdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_level_load       i_level_load,
    input  logic              i_advance,
    input  logic              i_raw_level,
    input  logic [TIME_W-1:0] i_now_ms,
    output t_result           o_result
);

    t_state            r_state;
    t_state            n_state;
    logic              w_accept;
    logic              w_guard_ok;
    logic              w_is_press;
    logic              w_fire;
    logic              w_reject;
    logic [TIME_W-1:0] w_duration;
    logic [TIME_W-1:0] w_since_event;
    logic [TIME_W-1:0] w_since_action;

    assign w_since_event  = i_now_ms - r_state.last_event_time;
    assign w_since_action = i_now_ms - r_state.last_action_time;

    // next state and result for the poll in the input register
    always_comb begin
        n_state    = r_state;
        w_accept   = 1'b0;
        w_guard_ok = 1'b0;
        w_is_press = 1'b0;
        w_fire     = 1'b0;
        w_reject   = 1'b0;
        w_duration = '0;

        // level qualification
        if (i_cfg.mode == MODE_COUNTING) begin
            if (i_raw_level == r_state.last_raw) begin
                if (r_state.same_polls < i_cfg.stable_polls) begin
                    n_state.same_polls = r_state.same_polls + POLLS_W'(1);
                end
            end else begin
                n_state.same_polls = '0;
                n_state.last_raw   = i_raw_level;
            end
            w_accept = (n_state.same_polls >= i_cfg.stable_polls)
                       && (i_raw_level != r_state.stable_now);
        end else if (i_raw_level != r_state.last_raw) begin
            w_guard_ok = !r_state.last_event_ok
                         || (w_since_event >= {{(TIME_W-MS_W){1'b0}}, i_cfg.guard_ms});
            n_state.last_raw = i_raw_level;
            w_accept = w_guard_ok && (i_raw_level != r_state.stable_now);
            if (w_accept) begin
                n_state.last_event_time = i_now_ms;
                n_state.last_event_ok   = 1'b1;
            end
        end

        // accepted edge: level, counters, press timing and action
        if (w_accept) begin
            n_state.stable_now  = i_raw_level;
            n_state.events_seen = r_state.events_seen + COUNT_W'(1);
            if (i_raw_level == LEVEL_PRESSED) begin
                w_is_press               = 1'b1;
                n_state.press_start_time = i_now_ms;
                n_state.press_start_ok   = 1'b1;
            end else if (r_state.press_start_ok) begin
                w_duration               = i_now_ms - r_state.press_start_time;
                n_state.press_start_ok   = 1'b0;
                n_state.press_start_time = '0;
            end
            if (w_is_press && (i_cfg.mode == MODE_GUARD)) begin
                if (r_state.last_action_ok
                    && (w_since_action < {{(TIME_W-MS_W){1'b0}}, i_cfg.cooldown_ms})) begin
                    w_reject                 = 1'b1;
                    n_state.actions_rejected = r_state.actions_rejected + COUNT_W'(1);
                end else begin
                    w_fire                   = 1'b1;
                    n_state.actions_fired    = r_state.actions_fired + COUNT_W'(1);
                    n_state.last_action_time = i_now_ms;
                    n_state.last_action_ok   = 1'b1;
                end
            end
        end
    end

    // state register; a fresh start level wins over a poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.stable_now       <= RST_INITIAL_LEVEL;
            r_state.last_raw         <= RST_INITIAL_LEVEL;
            r_state.same_polls       <= '0;
            r_state.last_event_time  <= '0;
            r_state.last_event_ok    <= 1'b0;
            r_state.press_start_time <= '0;
            r_state.press_start_ok   <= 1'b0;
            r_state.events_seen      <= '0;
            r_state.last_action_time <= '0;
            r_state.last_action_ok   <= 1'b0;
            r_state.actions_fired    <= '0;
            r_state.actions_rejected <= '0;
        end else if (i_level_load.load) begin
            r_state.stable_now <= i_level_load.level;
            r_state.last_raw   <= i_level_load.level;
            r_state.same_polls <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    // result fields
    assign o_result.stable_level      = n_state.stable_now;
    assign o_result.event_valid       = w_accept;
    assign o_result.event_is_press    = w_is_press;
    assign o_result.event_total       = n_state.events_seen;
    assign o_result.press_duration_ms = w_duration;
    assign o_result.action_fire       = w_fire;
    assign o_result.action_reject     = w_reject;
    assign o_result.action_total      = n_state.actions_fired;
    assign o_result.reject_total      = n_state.actions_rejected;

endmodule

// ----- sim/tb_key_debounce_with_cooldown.sv -----
// tb_key_debounce_with_cooldown: self-checking bench for the key debouncer with action cooldown
// depends on kdc_pkg, kdc_if and the key_debounce_with_cooldown rtl; polls are scored against
// an in-bench debouncer model or known results, a directed script first, then random phases
`timescale 1ns / 100ps

module tb_key_debounce_with_cooldown;
    import kdc_pkg::*;

    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_POLLS = 50;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;
    localparam int unsigned SETTLE_CYCLES = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef enum logic {ROW_POLL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  raw;
        logic [TIME_W-1:0]     now;
        logic                  known;
        t_result               want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kdc_in_if  in_ch ();
    kdc_cfg_if cfg_ch ();
    kdc_out_if out_ch ();

    key_debounce_with_cooldown uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // debouncer model state and register copy
    t_cfg        key_cfg;
    t_state      key_st;
    t_result     pending_results[$];
    t_script_row script[$];
    int          errors = 0;
    bit          calm = 1'b0;

    always #6 i_clk = ~i_clk;

    // restart from a fresh key level
    function automatic void load_level(logic lvl);
        key_st.stable_now = lvl;
        key_st.last_raw   = lvl;
        key_st.same_polls = '0;
    endfunction

    function automatic void reset_model();
        key_cfg.mode          = RST_MODE;
        key_cfg.stable_polls  = RST_STABLE_POLLS;
        key_cfg.guard_ms      = RST_GUARD_MS;
        key_cfg.cooldown_ms   = RST_COOLDOWN_MS;
        key_cfg.initial_level = RST_INITIAL_LEVEL;
        key_st = '0;
        load_level(RST_INITIAL_LEVEL);
    endfunction

    // register update as seen by the block
    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:          key_cfg.mode = data[0];
            CFG_STABLE_POLLS:  key_cfg.stable_polls = data[POLLS_W-1:0];
            CFG_GUARD_MS:      key_cfg.guard_ms = data[MS_W-1:0];
            CFG_COOLDOWN_MS:   key_cfg.cooldown_ms = data[MS_W-1:0];
            CFG_INITIAL_LEVEL: begin
                key_cfg.initial_level = data[0];
                load_level(data[0]);
            end
            default: ;
        endcase
    endfunction

    // one poll through the debouncer: level qualification, press timing, cooldown
    function automatic t_result debounce_poll(logic raw, logic [TIME_W-1:0] now);
        t_result           r;
        logic              take;
        logic [TIME_W-1:0] since;
        r    = '0;
        take = 1'b0;
        if (key_cfg.mode == MODE_COUNTING) begin
            if (raw == key_st.last_raw) begin
                if (key_st.same_polls < key_cfg.stable_polls)
                    key_st.same_polls = key_st.same_polls + 1'b1;
            end else begin
                key_st.same_polls = '0;
                key_st.last_raw   = raw;
            end
            take = (key_st.same_polls >= key_cfg.stable_polls) && (raw != key_st.stable_now);
        end else if (raw != key_st.last_raw) begin
            since = now - key_st.last_event_time;
            take  = (!key_st.last_event_ok || since >= {16'd0, key_cfg.guard_ms})
                    && (raw != key_st.stable_now);
            key_st.last_raw = raw;
            if (take) begin
                key_st.last_event_time = now;
                key_st.last_event_ok   = 1'b1;
            end
        end
        if (take) begin
            key_st.stable_now  = raw;
            key_st.events_seen = key_st.events_seen + 1;
            if (raw == LEVEL_PRESSED) begin
                r.event_is_press        = 1'b1;
                key_st.press_start_time = now;
                key_st.press_start_ok   = 1'b1;
            end else if (key_st.press_start_ok) begin
                r.press_duration_ms     = now - key_st.press_start_time;
                key_st.press_start_ok   = 1'b0;
                key_st.press_start_time = '0;
            end
            // presses in guard mode fire unless still inside the cooldown window
            if (r.event_is_press && key_cfg.mode == MODE_GUARD) begin
                since = now - key_st.last_action_time;
                if (key_st.last_action_ok && since < {16'd0, key_cfg.cooldown_ms}) begin
                    key_st.actions_rejected = key_st.actions_rejected + 1;
                    r.action_reject = 1'b1;
                end else begin
                    key_st.actions_fired    = key_st.actions_fired + 1;
                    key_st.last_action_time = now;
                    key_st.last_action_ok   = 1'b1;
                    r.action_fire = 1'b1;
                end
            end
        end
        r.stable_level = key_st.stable_now;
        r.event_valid  = take;
        r.event_total  = key_st.events_seen;
        r.action_total = key_st.actions_fired;
        r.reject_total = key_st.actions_rejected;
        return r;
    endfunction

    // idle lengths: mostly short, a few long, none in a calm stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_result outcome(logic stable, logic ev, logic press,
                                        logic [31:0] total, logic [31:0] dur, logic fire,
                                        logic rej, logic [31:0] fired, logic [31:0] rejected);
        return t_result'({stable, ev, press, total, dur, fire, rej, fired, rejected});
    endfunction

    // script rows
    function automatic void add_poll(logic raw, logic [TIME_W-1:0] now);
        script.push_back({ROW_POLL, {CFG_IDX_W{1'b0}}, {CFG_DATA_W{1'b0}}, raw, now, 1'b0,
                          t_result'('0)});
    endfunction

    function automatic void add_known(logic raw, logic [TIME_W-1:0] now, t_result want);
        script.push_back({ROW_POLL, {CFG_IDX_W{1'b0}}, {CFG_DATA_W{1'b0}}, raw, now, 1'b1,
                          want});
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        script.push_back({ROW_WRITE, idx, data, 1'b0, {TIME_W{1'b0}}, 1'b0, t_result'('0)});
    endfunction

    // poll transfer, then the prediction for it
    task automatic send_poll(logic raw, logic [TIME_W-1:0] now, logic known, t_result want);
        t_result predicted;
        int      gap;
        cfg_ch.valid    <= 1'b0;
        in_ch.valid     <= 1'b1;
        in_ch.raw_level <= raw;
        in_ch.now_ms    <= now;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = debounce_poll(raw, now);
        pending_results.push_back(known ? want : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write transfer; valid is dropped by the next poll or drain
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_write(idx, data);
    endtask

    // wait until every expected result has come back and the pipeline is empty
    task automatic wait_drained();
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // result sink with random stalls
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // score each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, event_total %0h", $time,
                         out_ch.event_total);
            end else begin
                want = pending_results.pop_front();
                check_field("stable_level", want.stable_level, out_ch.stable_level);
                check_field("event_valid", want.event_valid, out_ch.event_valid);
                check_field("event_is_press", want.event_is_press, out_ch.event_is_press);
                check_field("event_total", want.event_total, out_ch.event_total);
                check_field("press_duration_ms", want.press_duration_ms,
                            out_ch.press_duration_ms);
                check_field("action_fire", want.action_fire, out_ch.action_fire);
                check_field("action_reject", want.action_reject, out_ch.action_reject);
                check_field("action_total", want.action_total, out_ch.action_total);
                check_field("reject_total", want.reject_total, out_ch.reject_total);
            end
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] now;
        logic              key_level;
        logic              raw;
        logic              mode_sel;
        int                hold_left;
        int                bounce_left;
        int                hint;
        int                roll;
        logic [15:0]       value;

        in_ch.valid     <= 1'b0;
        in_ch.raw_level <= 1'b1;
        in_ch.now_ms    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_MODE;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        reset_model();

        // directed script, guard mode from reset first
        add_known(1'b1, 32'd0,   outcome(1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0, 0, 0));
        add_known(1'b0, 32'd0,   outcome(1'b0, 1'b1, 1'b1, 1, 0, 1'b1, 1'b0, 1, 0));
        add_known(1'b1, 32'd10,  outcome(1'b0, 1'b0, 1'b0, 1, 0, 1'b0, 1'b0, 1, 0));
        add_known(1'b1, 32'd100, outcome(1'b0, 1'b0, 1'b0, 1, 0, 1'b0, 1'b0, 1, 0));
        add_poll(1'b0, 32'd110);            // raw change back to the stable level
        add_poll(1'b1, 32'd200);            // timed release
        add_poll(1'b0, 32'd300);            // press inside cooldown
        add_poll(1'b1, 32'd400);
        add_poll(1'b0, 32'hFFFF_FFF0);      // press just before time wrap
        add_poll(1'b1, 32'h0000_0010);      // release across the wrap
        // counting mode, level accepted on the poll it appears
        add_write(CFG_MODE, {15'd0, MODE_COUNTING});
        add_write(CFG_STABLE_POLLS, 16'd0);
        add_poll(1'b0, 32'd20);
        add_write(CFG_STABLE_POLLS, 16'd4);
        add_poll(1'b1, 32'd30);
        add_poll(1'b1, 32'd31);
        add_poll(1'b1, 32'd32);
        // lowering the poll count takes effect straight away
        add_write(CFG_STABLE_POLLS, 16'd1);
        add_poll(1'b1, 32'd33);
        // fresh start level, then a release with no timed press
        add_write(CFG_INITIAL_LEVEL, 16'd0);
        add_poll(1'b0, 32'd40);
        add_poll(1'b1, 32'd41);
        add_poll(1'b1, 32'd42);
        // guard mode at the guard extremes, no cooldown
        add_write(CFG_MODE, {15'd0, MODE_GUARD});
        add_write(CFG_GUARD_MS, 16'hFFFF);
        add_write(CFG_COOLDOWN_MS, 16'd0);
        add_poll(1'b0, 32'd50);
        add_write(CFG_GUARD_MS, 16'd0);
        add_poll(1'b1, 32'd51);
        add_poll(1'b0, 32'd52);
        add_poll(1'b1, 32'd53);
        add_poll(1'b0, 32'd53);
        add_write(CFG_SPARE, 16'hFFFF);     // unused index, no effect
        add_poll(1'b1, 32'hFFFF_FFFF);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            if (script[n].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(script[n].idx, script[n].data);
            end else begin
                send_poll(script[n].raw, script[n].now, script[n].known, script[n].want);
            end
        end

        // random phases, each with its own register setting
        now = $urandom;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_drained();
            calm = ($urandom_range(0, 3) == 0);
            mode_sel = (phase % 2 == 1) ? MODE_GUARD : MODE_COUNTING;
            value = $urandom;
            write_reg(CFG_MODE, {value[15:1], mode_sel});
            roll = $urandom_range(0, 3);
            value = $urandom;
            value[POLLS_W-1:0] = (roll == 0) ? 4'd0 : (roll == 1) ? 4'd1
                                 : (roll == 2) ? 4'd15 : 4'($urandom_range(0, 15));
            write_reg(CFG_STABLE_POLLS, value);
            roll = $urandom_range(0, 4);
            value = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : (roll == 2) ? 16'd1
                    : 16'($urandom_range(2, 200));
            write_reg(CFG_GUARD_MS, value);
            roll = $urandom_range(0, 3);
            value = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(1, 2000));
            write_reg(CFG_COOLDOWN_MS, value);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_INITIAL_LEVEL, 16'($urandom));
            if ($urandom_range(0, 4) == 0)
                write_reg(3'($urandom_range(int'(CFG_INITIAL_LEVEL) + 1, 7)), 16'($urandom));
            if ($urandom_range(0, 2) == 0)
                now = 32'hFFFF_FFFF - $urandom_range(0, 3000);

            hint = (key_cfg.mode == MODE_GUARD) ? int'(key_cfg.guard_ms) / 3 + 1 : 20;
            key_level = key_st.stable_now;
            hold_left = 0;
            bounce_left = 0;
            for (int k = 0; k < PHASE_POLLS; k++) begin
                // key flips after a hold, with contact bounce after each flip
                if (hold_left == 0) begin
                    key_level = ~key_level;
                    hold_left = $urandom_range(1, int'(key_cfg.stable_polls) + 4);
                    bounce_left = $urandom_range(0, 3);
                end
                hold_left--;
                if (bounce_left > 0 || $urandom_range(0, 99) < 8)
                    raw = $urandom_range(0, 1);
                else
                    raw = key_level;
                if (bounce_left > 0)
                    bounce_left--;
                // time steps around the guard and cooldown, now and then a jump
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    now = now;
                else if (roll < 60)
                    now = now + $urandom_range(1, hint);
                else if (roll < 85)
                    now = now + $urandom_range(hint, 3 * hint);
                else if (roll < 95)
                    now = now + $urandom_range(int'(key_cfg.cooldown_ms) / 2,
                                               int'(key_cfg.cooldown_ms) + 50);
                else
                    now = $urandom;
                send_poll(raw, now, 1'b0, t_result'('0));
            end
        end

        calm = 1'b1;
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard limit on the run
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- key_debounce_with_cooldown.f -----
rtl/kdc_pkg.sv
rtl/kdc_if.sv
rtl/kdc_cfg.sv
rtl/kdc_engine.sv
rtl/key_debounce_with_cooldown.sv
sim/tb_key_debounce_with_cooldown.sv
